// ===== rtl/rwms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwms_pkg
// Shared types and constants of the robot work mode supervisor.
// ----------------------------------------------------------------------------
package rwms_pkg;

    // Widths fixed by the item fields and the configuration registers.
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int IN_SLOT_W   = 8;

    localparam int SLOTS_DEFAULT = 8;

    localparam logic [CFG_W-1:0] PREPARE_TICKS_RST = 16'd500;
    localparam logic [CFG_W-1:0] SWITCH_TICKS_RST  = 16'd50;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_PREPARE_TICKS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_TICKS  = 1'd1;

    // Remote input source codes.
    localparam logic [1:0] IMODE_REMOTE   = 2'd0;
    localparam logic [1:0] IMODE_KEYMOUSE = 2'd1;
    localparam logic [1:0] IMODE_STOP     = 2'd2;
    localparam logic [1:0] IMODE_OTHER    = 2'd3;

    // Function switch positions.
    localparam logic [1:0] SW_UPPER  = 2'd0;
    localparam logic [1:0] SW_MIDDLE = 2'd1;
    localparam logic [1:0] SW_LOWER  = 2'd2;
    localparam logic [1:0] SW_NONE   = 2'd3;

    typedef enum logic [2:0] {
        MODE_PREPARE = 3'd0,
        MODE_NORMAL  = 3'd1,
        MODE_EXTRA1  = 3'd2,
        MODE_EXTRA2  = 3'd3,
        MODE_STOP    = 3'd4
    } t_mode;

    // Control fields of one tick, as seen by the mode machine.
    typedef struct packed {
        logic [1:0] input_mode;
        logic [1:0] switch_pos;
        logic       imu_ready;
        logic       motor_conflict;
    } t_tick;

    // Self-check state after the current tick.
    typedef struct packed {
        logic [IN_SLOT_W-1:0] slot_leds;
        logic                 bus1_led;
        logic                 bus2_led;
        logic                 motors_ok;
    } t_check;

endpackage : rwms_pkg
`default_nettype wire

// ===== rtl/rwms_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwms_check
// Motor self-check: drives the fault LEDs until every motor has reported.
// ----------------------------------------------------------------------------
module rwms_check #(
    parameter int SLOTS = rwms_pkg::SLOTS_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic [rwms_pkg::IN_SLOT_W-1:0]     i_bus1_silent,
    input  wire logic [rwms_pkg::IN_SLOT_W-1:0]     i_bus2_silent,
    output rwms_pkg::t_check                        o_check
);

    localparam logic [rwms_pkg::IN_SLOT_W-1:0] SlotMask =
        (SLOTS >= rwms_pkg::IN_SLOT_W) ? {rwms_pkg::IN_SLOT_W{1'b1}}
                                       : rwms_pkg::IN_SLOT_W'((1 << SLOTS) - 1);

    rwms_pkg::t_check r_check;
    rwms_pkg::t_check n_check;

    logic [rwms_pkg::IN_SLOT_W-1:0] s1;
    logic [rwms_pkg::IN_SLOT_W-1:0] s2;

    assign s1 = i_bus1_silent & SlotMask;
    assign s2 = i_bus2_silent & SlotMask;

    // Once the flag is latched the check stops and the LEDs hold.
    always_comb begin
        n_check = r_check;
        if (!r_check.motors_ok) begin
            n_check.slot_leds = s1 | s2;
            n_check.bus1_led  = |s1;
            n_check.bus2_led  = |s2;
            n_check.motors_ok = ~(|s1) & ~(|s2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= '0;
        end else if (i_en) begin
            r_check <= n_check;
        end
    end

    assign o_check = n_check;

    a_ok_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_check.motors_ok |=> r_check.motors_ok)
        else $error("motors_ok flag dropped after being latched");

    a_leds_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_check.motors_ok |=> $stable(r_check.slot_leds) && $stable(r_check.bus1_led)
                              && $stable(r_check.bus2_led))
        else $error("fault LEDs changed after the self-check finished");

endmodule : rwms_check
`default_nettype wire

// ===== rtl/rwms_mode_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwms_mode_fsm
// Five-state work mode machine with prepare and switch position counters.
// ----------------------------------------------------------------------------
module rwms_mode_fsm (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire rwms_pkg::t_tick                i_tick,
    input  wire logic                           i_motors_ok,
    input  wire logic [rwms_pkg::CFG_W-1:0]     i_prepare_ticks,
    input  wire logic [rwms_pkg::CFG_W-1:0]     i_switch_ticks,
    output rwms_pkg::t_mode                     o_mode,
    output logic                                o_stop_reset
);

    localparam int NumCnt = 6;

    typedef struct packed {
        logic                       fire_a;
        logic                       fire_b;
        logic [rwms_pkg::CFG_W-1:0] cnt_a;
        logic [rwms_pkg::CFG_W-1:0] cnt_b;
    } t_pair;

    // Two switch counters of one mode; a full count on the second wins.
    function automatic t_pair pair_step(
        input logic [1:0]                 sw,
        input logic [1:0]                 pos_a,
        input logic [1:0]                 pos_b,
        input logic [rwms_pkg::CFG_W-1:0] ca,
        input logic [rwms_pkg::CFG_W-1:0] cb,
        input logic [rwms_pkg::CFG_W-1:0] lim
    );
        logic [rwms_pkg::CFG_W-1:0] a1;
        logic [rwms_pkg::CFG_W-1:0] b0;
        logic [rwms_pkg::CFG_W-1:0] b1;
        t_pair                      r;
        a1 = ca + rwms_pkg::CFG_W'(sw == pos_a);
        r.fire_a = (a1 >= lim);
        b0 = r.fire_a ? '0 : cb;
        b1 = b0 + rwms_pkg::CFG_W'(sw == pos_b);
        r.fire_b = (b1 >= lim);
        r.cnt_a = (r.fire_a || r.fire_b) ? '0 : a1;
        r.cnt_b = r.fire_b ? '0 : b1;
        return r;
    endfunction

    rwms_pkg::t_mode             r_mode;
    rwms_pkg::t_mode             n_mode;
    logic [rwms_pkg::CFG_W-1:0]  r_prep_cnt;
    logic [rwms_pkg::CFG_W-1:0]  n_prep_cnt;
    logic [rwms_pkg::CFG_W-1:0]  r_sw_cnt [NumCnt];
    logic [rwms_pkg::CFG_W-1:0]  n_sw_cnt [NumCnt];

    logic                        stop_req;
    logic                        prep_inc;
    logic [rwms_pkg::CFG_W-1:0]  prep_next;
    t_pair                       p_norm;
    t_pair                       p_ext1;
    t_pair                       p_ext2;

    assign stop_req  = (i_tick.input_mode == rwms_pkg::IMODE_STOP);
    assign prep_inc  = (r_prep_cnt < i_prepare_ticks) && i_tick.imu_ready
                       && i_motors_ok && !i_tick.motor_conflict;
    assign prep_next = r_prep_cnt + rwms_pkg::CFG_W'(prep_inc);

    assign p_norm = pair_step(i_tick.switch_pos, rwms_pkg::SW_MIDDLE, rwms_pkg::SW_LOWER,
                              r_sw_cnt[0], r_sw_cnt[1], i_switch_ticks);
    assign p_ext1 = pair_step(i_tick.switch_pos, rwms_pkg::SW_UPPER, rwms_pkg::SW_LOWER,
                              r_sw_cnt[2], r_sw_cnt[3], i_switch_ticks);
    assign p_ext2 = pair_step(i_tick.switch_pos, rwms_pkg::SW_UPPER, rwms_pkg::SW_MIDDLE,
                              r_sw_cnt[4], r_sw_cnt[5], i_switch_ticks);

    // Next state and counters.
    always_comb begin
        n_mode     = r_mode;
        n_prep_cnt = r_prep_cnt;
        n_sw_cnt   = r_sw_cnt;
        unique case (r_mode)
            rwms_pkg::MODE_PREPARE: begin
                if (stop_req) n_mode = rwms_pkg::MODE_STOP;
                if (prep_next >= i_prepare_ticks) begin
                    n_mode     = rwms_pkg::MODE_NORMAL;
                    n_prep_cnt = '0;
                end else begin
                    n_prep_cnt = prep_next;
                end
            end
            rwms_pkg::MODE_NORMAL: begin
                if (stop_req) n_mode = rwms_pkg::MODE_STOP;
                if (p_norm.fire_a) n_mode = rwms_pkg::MODE_EXTRA1;
                if (p_norm.fire_b) n_mode = rwms_pkg::MODE_EXTRA2;
                n_sw_cnt[0] = p_norm.cnt_a;
                n_sw_cnt[1] = p_norm.cnt_b;
            end
            rwms_pkg::MODE_EXTRA1: begin
                if (stop_req) n_mode = rwms_pkg::MODE_STOP;
                if (p_ext1.fire_a) n_mode = rwms_pkg::MODE_NORMAL;
                if (p_ext1.fire_b) n_mode = rwms_pkg::MODE_EXTRA2;
                n_sw_cnt[2] = p_ext1.cnt_a;
                n_sw_cnt[3] = p_ext1.cnt_b;
            end
            rwms_pkg::MODE_EXTRA2: begin
                if (stop_req) n_mode = rwms_pkg::MODE_STOP;
                if (p_ext2.fire_a) n_mode = rwms_pkg::MODE_NORMAL;
                if (p_ext2.fire_b) n_mode = rwms_pkg::MODE_EXTRA1;
                n_sw_cnt[4] = p_ext2.cnt_a;
                n_sw_cnt[5] = p_ext2.cnt_b;
            end
            rwms_pkg::MODE_STOP: begin
                if (i_tick.input_mode == rwms_pkg::IMODE_REMOTE ||
                    i_tick.input_mode == rwms_pkg::IMODE_KEYMOUSE) begin
                    n_mode = rwms_pkg::MODE_PREPARE;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Outputs of the tick.
    always_comb begin
        o_mode       = n_mode;
        o_stop_reset = (r_mode == rwms_pkg::MODE_STOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= rwms_pkg::MODE_PREPARE;
            r_prep_cnt <= '0;
            for (int i = 0; i < NumCnt; i++) begin
                r_sw_cnt[i] <= '0;
            end
        end else if (i_en) begin
            r_mode     <= n_mode;
            r_prep_cnt <= n_prep_cnt;
            r_sw_cnt   <= n_sw_cnt;
        end
    end

    a_stop_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == rwms_pkg::MODE_STOP) |=>
            (r_mode == rwms_pkg::MODE_STOP || r_mode == rwms_pkg::MODE_PREPARE))
        else $error("stop mode left for a mode other than prepare");

endmodule : rwms_mode_fsm
`default_nettype wire

// ===== rtl/robot_work_mode_supervisor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// robot_work_mode_supervisor_core
// Work mode supervisor: motor self-check and five-state mode machine.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one control tick and yields exactly one
// result request on the master stream. A request is taken into an input
// register; once the output register is empty or being drained, the
// self-check and the mode machine update their state and the result is
// written into the output register, which presents it on tdata (two
// register stages). The block takes one request per clock cycle, sustained,
// for as long as the master side keeps taking results. Both registers carry
// their own valid flag, so a new request is taken while a finished result
// still waits for the downstream tready. The prepare_ticks and switch_ticks
// registers are written through the plain write port (index 0 and 1) and are
// expected to change only while no tick is in flight.
// ----------------------------------------------------------------------------
module robot_work_mode_supervisor_core #(
    parameter int SLOTS = rwms_pkg::SLOTS_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [rwms_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [rwms_pkg::CFG_W-1:0]         i_cfg_data,

    // Tick input stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata from bit 0: input_mode[1:0], switch_pos[3:2], imu_ready[4],
    // motor_conflict[5], bus1_silent[13:6], bus2_silent[21:14], zeros.
    input  wire logic [rwms_pkg::S_TDATA_W-1:0]     s_axis_tdata,

    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata from bit 0: mode[2:0], slot_fault_leds[10:3], bus1_fault_led[11],
    // bus2_fault_led[12], motors_ok[13], stop_reset[14], zero[15].
    output logic [rwms_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    // Configuration registers, reset to their documented defaults.
    logic [rwms_pkg::CFG_W-1:0] r_prepare_ticks;
    logic [rwms_pkg::CFG_W-1:0] r_switch_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prepare_ticks <= rwms_pkg::PREPARE_TICKS_RST;
            r_switch_ticks  <= rwms_pkg::SWITCH_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rwms_pkg::CFG_PREPARE_TICKS: r_prepare_ticks <= i_cfg_data;
                rwms_pkg::CFG_SWITCH_TICKS:  r_switch_ticks  <= i_cfg_data;
                default: begin
                    r_prepare_ticks <= r_prepare_ticks;
                end
            endcase
        end
    end

    // Input register. The tick is processed when it can move into the
    // output register, i.e. that register is empty or being drained.
    logic                               r_in_valid;
    rwms_pkg::t_tick                    r_in_tick;
    logic [rwms_pkg::IN_SLOT_W-1:0]     r_in_bus1;
    logic [rwms_pkg::IN_SLOT_W-1:0]     r_in_bus2;

    logic                               r_out_valid;
    logic [rwms_pkg::M_TDATA_W-1:0]     r_out_data;

    logic                               advance;
    logic                               in_take;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tick.input_mode     <= s_axis_tdata[1:0];
            r_in_tick.switch_pos     <= s_axis_tdata[3:2];
            r_in_tick.imu_ready      <= s_axis_tdata[4];
            r_in_tick.motor_conflict <= s_axis_tdata[5];
            r_in_bus1                <= s_axis_tdata[13:6];
            r_in_bus2                <= s_axis_tdata[21:14];
        end
    end

    // Self-check runs first; the mode machine sees the flag it just produced.
    rwms_pkg::t_check   check;
    rwms_pkg::t_mode    mode_next;
    logic               stop_reset;

    rwms_check #(
        .SLOTS          (SLOTS)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_bus1_silent  (r_in_bus1),
        .i_bus2_silent  (r_in_bus2),
        .o_check        (check)
    );

    rwms_mode_fsm u_mode_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_tick          (r_in_tick),
        .i_motors_ok     (check.motors_ok),
        .i_prepare_ticks (r_prepare_ticks),
        .i_switch_ticks  (r_switch_ticks),
        .o_mode          (mode_next),
        .o_stop_reset    (stop_reset)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {1'b0, stop_reset, check.motors_ok, check.bus2_led,
                           check.bus1_led, check.slot_leds, mode_next};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Once the motors are reported, the check that latched the flag saw no
    // silent motor, so every fault LED stays dark.
    a_ok_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[13]) |-> (r_out_data[12:3] == '0))
        else $error("fault LED lit while motors_ok is set");

    // During the self-check the bus LEDs agree with the slot LEDs.
    a_led_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[13]) |->
            ((r_out_data[10:3] != '0) == (r_out_data[11] || r_out_data[12])))
        else $error("bus fault LEDs disagree with slot fault LEDs");

    // The reset strobe only comes from a tick processed in stop mode.
    a_strobe_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[14]) |->
            (r_out_data[2:0] == rwms_pkg::MODE_STOP ||
             r_out_data[2:0] == rwms_pkg::MODE_PREPARE))
        else $error("stop strobe with a mode not reachable from stop");

endmodule : robot_work_mode_supervisor_core
`default_nettype wire

// ===== dv/robot_work_mode_supervisor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// robot_work_mode_supervisor_checker
// Watches the tick and result streams and the register write port. It keeps a
// model of the mode machine and the motor self-check, and compares every
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module robot_work_mode_supervisor_checker #(
    parameter int SLOTS = rwms_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rwms_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [rwms_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    // input_mode, switch_pos, imu_ready, motor_conflict, bus1_silent,
    // bus2_silent, zeros
    input  wire logic [rwms_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // mode, slot_fault_leds, bus1_fault_led, bus2_fault_led, motors_ok,
    // stop_reset, zero
    input  wire logic [rwms_pkg::M_TDATA_W-1:0]  i_m_tdata,
    output int                                   o_pending,
    output int                                   o_errors
);

    import rwms_pkg::*;

    localparam logic [IN_SLOT_W-1:0] SLOT_MASK =
        (SLOTS >= IN_SLOT_W) ? '1 : IN_SLOT_W'((1 << SLOTS) - 1);

    // Packed in the same order as the result tdata, lowest field last.
    typedef struct packed {
        logic                 stop_reset;
        logic                 motors_ok;
        logic                 bus2_led;
        logic                 bus1_led;
        logic [IN_SLOT_W-1:0] slot_leds;
        logic [2:0]           mode;
    } t_status;

    logic [CFG_W-1:0] prep_limit;
    logic [CFG_W-1:0] switch_limit;
    t_mode            mode_q;
    logic             ok_q;
    logic [9:0]       leds_q;
    logic [15:0]      prep_cnt;
    logic [15:0]      switch_cnt [6];
    t_status          status_due [$];
    int               errors = 0;

    // Counts one tick on position a or b; a full count moves the mode and
    // clears both counts of the pair. The second check wins if both fire.
    task automatic count_switch(input logic [1:0] sw,
                                input logic [1:0] pos_a, input int a, input t_mode to_a,
                                input logic [1:0] pos_b, input int b, input t_mode to_b);
        if (sw == pos_a)
            switch_cnt[a] = switch_cnt[a] + 16'd1;
        if (switch_cnt[a] >= switch_limit) begin
            mode_q        = to_a;
            switch_cnt[a] = '0;
            switch_cnt[b] = '0;
        end
        if (sw == pos_b)
            switch_cnt[b] = switch_cnt[b] + 16'd1;
        if (switch_cnt[b] >= switch_limit) begin
            mode_q        = to_b;
            switch_cnt[a] = '0;
            switch_cnt[b] = '0;
        end
    endtask

    task automatic advance_tick(input logic [S_TDATA_W-1:0] d, output t_status st);
        logic [1:0]           imode;
        logic [1:0]           sw;
        logic                 imu;
        logic                 conflict;
        logic [IN_SLOT_W-1:0] s1;
        logic [IN_SLOT_W-1:0] s2;
        imode    = d[1:0];
        sw       = d[3:2];
        imu      = d[4];
        conflict = d[5];
        s1       = d[13:6] & SLOT_MASK;
        s2       = d[21:14] & SLOT_MASK;
        st.stop_reset = 1'b0;

        // The self-check reruns until no motor has been silent on a tick.
        if (!ok_q) begin
            leds_q = {s2 != '0, s1 != '0, s1 | s2};
            ok_q   = (s1 == '0) && (s2 == '0);
        end

        case (mode_q)
            MODE_PREPARE: begin
                if (imode == IMODE_STOP)
                    mode_q = MODE_STOP;
                if (prep_cnt < prep_limit && imu && ok_q && !conflict)
                    prep_cnt = prep_cnt + 16'd1;
                if (prep_cnt >= prep_limit) begin
                    mode_q   = MODE_NORMAL;
                    prep_cnt = '0;
                end
            end
            MODE_NORMAL: begin
                if (imode == IMODE_STOP)
                    mode_q = MODE_STOP;
                count_switch(sw, SW_MIDDLE, 0, MODE_EXTRA1, SW_LOWER, 1, MODE_EXTRA2);
            end
            MODE_EXTRA1: begin
                if (imode == IMODE_STOP)
                    mode_q = MODE_STOP;
                count_switch(sw, SW_UPPER, 2, MODE_NORMAL, SW_LOWER, 3, MODE_EXTRA2);
            end
            MODE_EXTRA2: begin
                if (imode == IMODE_STOP)
                    mode_q = MODE_STOP;
                count_switch(sw, SW_UPPER, 4, MODE_NORMAL, SW_MIDDLE, 5, MODE_EXTRA1);
            end
            MODE_STOP: begin
                if (imode == IMODE_REMOTE || imode == IMODE_KEYMOUSE)
                    mode_q = MODE_PREPARE;
                st.stop_reset = 1'b1;
            end
            default: ;
        endcase

        st.mode      = mode_q;
        st.slot_leds = leds_q[7:0];
        st.bus1_led  = leds_q[8];
        st.bus2_led  = leds_q[9];
        st.motors_ok = ok_q;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_status want;
        t_status got;
        if (!i_rst_n) begin
            prep_limit   = PREPARE_TICKS_RST;
            switch_limit = SWITCH_TICKS_RST;
            mode_q       = MODE_PREPARE;
            ok_q         = 1'b0;
            leds_q       = '0;
            prep_cnt     = '0;
            foreach (switch_cnt[k])
                switch_cnt[k] = '0;
            status_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PREPARE_TICKS: prep_limit   = i_cfg_data;
                    CFG_SWITCH_TICKS:  switch_limit = i_cfg_data;
                    default: ;
                endcase
            end
            // Results are retired before new requests are predicted, so a
            // result can never be matched against a tick taken on its own edge.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[14:0];
                if (status_due.size() == 0) begin
                    $error("result request with no tick outstanding: %h", i_m_tdata);
                    errors++;
                end else begin
                    want = status_due.pop_front();
                    compare_field("mode", want.mode, got.mode);
                    compare_field("slot_fault_leds", want.slot_leds, got.slot_leds);
                    compare_field("bus1_fault_led", want.bus1_led, got.bus1_led);
                    compare_field("bus2_fault_led", want.bus2_led, got.bus2_led);
                    compare_field("motors_ok", want.motors_ok, got.motors_ok);
                    compare_field("stop_reset", want.stop_reset, got.stop_reset);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_tick(i_s_tdata, want);
                status_due.push_back(want);
            end
        end
        o_pending = status_due.size();
        o_errors  = errors;
    end

endmodule

// ===== dv/robot_work_mode_supervisor_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// robot_work_mode_supervisor_core_tb
// Drives control ticks into the work mode supervisor and judges the run.
// A short directed opening walks the motor self-check, the stop and prepare
// paths and the zero-limit corner; random phases under several register
// settings then exercise the mode machine, with idling on both streams.
// ----------------------------------------------------------------------------
module robot_work_mode_supervisor_core_tb;

    import rwms_pkg::*;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int pending;
    int errors;

    // When set, neither stream idles; used for the back-to-back stretches.
    bit burst_mode    = 1'b0;
    // Asks the result sink for one long hold-off so that the block backs up.
    bit long_hold_req = 1'b0;

    // The switch tends to stay in one position for a while, as a driver's
    // hand would leave it, so that counts build up towards the limits.
    logic [1:0] sw_held = SW_NONE;

    logic [1:0] imode_order [4] = '{IMODE_REMOTE, IMODE_KEYMOUSE, IMODE_OTHER, IMODE_STOP};
    logic [1:0] sw_order    [4] = '{SW_UPPER, SW_MIDDLE, SW_LOWER, SW_NONE};

    always #1 i_clk = ~i_clk;

    robot_work_mode_supervisor_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    robot_work_mode_supervisor_checker #(
        .SLOTS (SLOTS_DEFAULT)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Idle length: none in burst mode; else mostly none, otherwise drawn from one of three ranges, the longest rarely.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one tick request and returns at the falling edge after it has
    // been taken. tvalid stays high into the next request unless a gap is drawn.
    task automatic send_tick(input logic [1:0] imode, input logic [1:0] sw,
                             input logic imu, input logic conflict,
                             input logic [7:0] s1, input logic [7:0] s2);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, s2, s1, conflict, imu, sw, imode};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Mostly well-formed ticks: remote or key-and-mouse control with the IMU
    // up and no conflict, broken now and then by stop requests, other sources,
    // a lagging IMU or a conflict. The silent masks are pure noise.
    task automatic send_random_tick();
        int         r;
        logic [1:0] imode;
        r = $urandom_range(0, 99);
        if (r < 80)
            imode = $urandom_range(0, 1) ? IMODE_KEYMOUSE : IMODE_REMOTE;
        else if (r < 88)
            imode = IMODE_STOP;
        else
            imode = IMODE_OTHER;
        if ($urandom_range(0, 3) == 0)
            sw_held = 2'($urandom_range(0, 3));
        send_tick(imode, sw_held, $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 8,
                  8'($urandom), 8'($urandom));
    endtask

    // Registers only change with nothing in flight: wait for every result, then
    // let the clock run on past the two-stage pipeline before writing.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] prep, input logic [CFG_W-1:0] sw_lim,
                             input int n, input bit burst, input bit squeeze);
        write_reg(CFG_PREPARE_TICKS, prep);
        write_reg(CFG_SWITCH_TICKS, sw_lim);
        burst_mode = burst;
        if (squeeze)
            long_hold_req = 1'b1;
        repeat (n) send_random_tick();
        burst_mode = 1'b0;
    endtask

    // Result sink. Stalls at random, and once takes a long hold-off while the
    // sender keeps offering ticks, so both pipeline registers fill and the
    // block has to drop its tready.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Self-check with the reset limits. Silent motors on one bus, the
        // other, both, and single edge slots keep the LEDs moving; a stop
        // request and a release from stop happen before the check passes.
        send_tick(IMODE_REMOTE,   SW_MIDDLE, 1'b1, 1'b0, 8'hFF, 8'h00);
        send_tick(IMODE_STOP,     SW_UPPER,  1'b0, 1'b1, 8'h00, 8'hFF);
        send_tick(IMODE_OTHER,    SW_NONE,   1'b1, 1'b0, 8'hAA, 8'h55);
        send_tick(IMODE_KEYMOUSE, SW_LOWER,  1'b0, 1'b0, 8'h01, 8'h80);
        // No motor silent: the check passes and latches, and prepare counts
        // on the very same tick.
        send_tick(IMODE_REMOTE,   SW_MIDDLE, 1'b1, 1'b0, 8'h00, 8'h00);
        // From here the LEDs hold; a conflict keeps prepare from counting.
        send_tick(IMODE_REMOTE,   SW_UPPER,  1'b1, 1'b1, 8'hFF, 8'hFF);
        // Leaving prepare for stop keeps the prepare count.
        send_tick(IMODE_STOP,     SW_NONE,   1'b1, 1'b0, 8'h0F, 8'hF0);
        send_tick(IMODE_REMOTE,   SW_NONE,   1'b1, 1'b0, 8'h00, 8'h00);

        // Both limits at zero: every move fires on the first tick spent in
        // its mode, the second switch check of a pair wins, and prepare done
        // overrides a stop request on the same tick.
        write_reg(CFG_PREPARE_TICKS, 16'd0);
        write_reg(CFG_SWITCH_TICKS, 16'd0);
        for (int i = 0; i < 16; i++)
            send_tick(imode_order[i % 4], sw_order[i / 4], i[0], i == 9,
                      8'($urandom), 8'($urandom));

        // Random phases. The first holds both limits at their maximum, so the
        // switch counts climb; a later one lowers the switch limit below them
        // and a move fires on the first tick spent in the mode.
        run_phase(16'hFFFF, 16'hFFFF, 60, 1'b0, 1'b0);
        run_phase(16'd1, 16'hFFFF, 80, 1'b0, 1'b0);
        run_phase(16'd3, 16'd2, 150, 1'b0, 1'b0);
        run_phase(16'd2, 16'd1, 100, 1'b1, 1'b0);
        run_phase(16'd8, 16'd5, 150, 1'b0, 1'b1);
        run_phase(16'($urandom_range(1, 10)), 16'($urandom_range(1, 6)), 160, 1'b0, 1'b0);

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("[robot_work_mode_supervisor_core] OK");
        else
            $display("[robot_work_mode_supervisor_core] ERROR");
        $finish;
    end

    // Backstop against a hung handshake: far beyond the slowest correct run.
    initial begin : watchdog
        #1_000_000;
        $display("[robot_work_mode_supervisor_core] ERROR");
        $finish;
    end

endmodule
